### rtl/tsc_pkg.sv
// shared types and constants of the triggered sample capture block
package tsc_pkg;

    // request codes carried by req_type
    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_ARM    = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    // register map, decoded on the word index bit of paddr
    localparam logic       REG_HIST_SIZE = 1'b0;
    localparam logic [5:0] HIST_SIZE_RST = 6'd32;

    // sequencer states
    typedef enum logic {
        ST_RUN,
        ST_DUMP
    } t_state;

    // configuration write toward the controller
    typedef struct packed {
        logic       wr;
        logic [5:0] size;
    } t_cfg;

endpackage

### rtl/tsc_hist_mem.sv
// history sample memory, one write port and one registered read port
module tsc_hist_mem #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/tsc_ctrl.sv
// trigger counters, history pointers, dump sequencer and result register
module tsc_ctrl #(
    parameter int HISTORY_DEPTH = 32,
    parameter int SAMPLE_BITS   = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tsc_pkg::t_cfg                    i_cfg,
    // request channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_req_type,
    input  logic signed [SAMPLE_BITS-1:0]    i_sample_value,
    input  logic [15:0]                      i_trig_length,
    input  logic signed [15:0]               i_trig_offset,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_has_value,
    output logic signed [SAMPLE_BITS-1:0]    o_value,
    output logic                             o_active,
    output logic                             o_last,
    output logic                             o_dumping,
    // history memory
    output logic                             o_mem_we,
    output logic [$clog2(HISTORY_DEPTH)-1:0] o_mem_waddr,
    output logic [SAMPLE_BITS-1:0]           o_mem_wdata,
    output logic                             o_mem_re,
    output logic [$clog2(HISTORY_DEPTH)-1:0] o_mem_raddr,
    input  logic [SAMPLE_BITS-1:0]           i_mem_rdata
);

    localparam int PW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam logic [6:0]    DEPTH7    = 7'(HISTORY_DEPTH);
    localparam logic [PW-1:0] PTR_LAST  = PW'(HISTORY_DEPTH - 1);
    localparam logic [PW:0]   DEPTH_X   = (PW + 1)'(HISTORY_DEPTH);
    localparam logic [PW:0]   DEPTH_M1X = (PW + 1)'(HISTORY_DEPTH - 1);

    tsc_pkg::t_state r_state, n_state;
    logic [PW-1:0]   r_wptr, n_wptr;
    logic [CW-1:0]   r_fill, n_fill;
    logic [15:0]     r_remain, n_remain;
    logic [14:0]     r_delay, n_delay;
    logic [PW-1:0]   r_rptr, n_rptr;
    logic [PW-1:0]   r_left, n_left;
    logic [5:0]      r_size;

    logic                          r_out_valid, n_out_valid;
    logic                          r_has, n_has;
    logic signed [SAMPLE_BITS-1:0] r_value, n_value;
    logic                          r_active, n_active;
    logic                          r_last, n_last;

    logic          can_load;
    logic          in_acc;
    logic [6:0]    lim7;
    logic [CW-1:0] lim;
    logic [6:0]    new_lim7;
    logic [CW-1:0] new_lim;
    logic          busy;
    logic [16:0]   back;
    logic [16:0]   fill_m1;
    logic [PW-1:0] k_first;
    logic [PW:0]   addr_sum;
    logic [PW-1:0] addr_first;
    logic [PW-1:0] rptr_next;

    // keep limit from the live size and from a size being written
    assign lim7     = ({1'b0, r_size} > DEPTH7) ? DEPTH7 : {1'b0, r_size};
    assign lim      = CW'(lim7);
    assign new_lim7 = ({1'b0, i_cfg.size} > DEPTH7) ? DEPTH7 : {1'b0, i_cfg.size};
    assign new_lim  = CW'(new_lim7);

    assign busy = (r_remain != '0) || (r_delay != '0);

    // look-back depth, clipped to the oldest stored sample
    assign back     = {1'b0, ~i_trig_offset} + 17'd1;
    assign fill_m1  = 17'(r_fill) - 17'd1;
    assign k_first  = (back < fill_m1) ? PW'(back) : PW'(fill_m1);
    assign addr_sum = {1'b0, r_wptr} + DEPTH_M1X - {1'b0, k_first};
    assign addr_first = (addr_sum >= DEPTH_X) ? PW'(addr_sum - DEPTH_X) : PW'(addr_sum);
    assign rptr_next  = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;

    // handshake
    assign can_load   = !r_out_valid || !i_out_stall;
    assign in_acc     = (r_state == tsc_pkg::ST_RUN) && i_in_valid && can_load;
    assign o_in_stall = !((r_state == tsc_pkg::ST_RUN) && can_load);

    // next state, counters, memory access and result
    always_comb begin
        n_state     = r_state;
        n_wptr      = r_wptr;
        n_fill      = r_fill;
        n_remain    = r_remain;
        n_delay     = r_delay;
        n_rptr      = r_rptr;
        n_left      = r_left;
        n_out_valid = r_out_valid && i_out_stall;
        n_has       = r_has;
        n_value     = r_value;
        n_active    = r_active;
        n_last      = r_last;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_wptr;
        o_mem_wdata = i_sample_value;
        o_mem_re    = 1'b0;
        o_mem_raddr = addr_first;

        case (r_state)
            tsc_pkg::ST_RUN: begin
                if (in_acc) begin
                    n_out_valid = 1'b1;
                    n_has       = 1'b0;
                    n_value     = '0;
                    n_last      = 1'b1;
                    case (i_req_type)
                        tsc_pkg::REQ_SAMPLE: begin
                            if (lim != '0) begin
                                o_mem_we = 1'b1;
                                n_wptr   = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
                                if (r_fill < lim) begin
                                    n_fill = r_fill + 1'b1;
                                end
                            end
                            if (r_delay != '0) begin
                                n_delay = r_delay - 1'b1;
                            end else if (r_remain != '0) begin
                                n_remain = r_remain - 1'b1;
                                n_has    = 1'b1;
                                n_value  = i_sample_value;
                            end
                        end
                        tsc_pkg::REQ_ARM: begin
                            if (!busy) begin
                                n_remain = i_trig_length;
                                if (!i_trig_offset[15]) begin
                                    n_delay = i_trig_offset[14:0];
                                end else begin
                                    n_delay = '0;
                                    if (r_fill != '0) begin
                                        // replay starts next cycle from the read port
                                        n_out_valid = r_out_valid && i_out_stall;
                                        n_has       = r_has;
                                        n_value     = r_value;
                                        n_last      = r_last;
                                        o_mem_re    = 1'b1;
                                        n_rptr      = addr_first;
                                        n_left      = k_first;
                                        n_state     = tsc_pkg::ST_DUMP;
                                    end
                                end
                            end
                        end
                        tsc_pkg::REQ_CLEAR: begin
                            n_remain = '0;
                            n_delay  = '0;
                        end
                        default: begin
                        end
                    endcase
                    n_active = (n_remain != '0) || (n_delay != '0);
                end
            end
            tsc_pkg::ST_DUMP: begin
                if (can_load) begin
                    n_out_valid = 1'b1;
                    n_has       = 1'b1;
                    n_value     = i_mem_rdata;
                    n_active    = busy;
                    n_last      = (r_left == '0);
                    if (r_left == '0) begin
                        n_state = tsc_pkg::ST_RUN;
                    end else begin
                        n_left      = r_left - 1'b1;
                        n_rptr      = rptr_next;
                        o_mem_re    = 1'b1;
                        o_mem_raddr = rptr_next;
                    end
                end
            end
            default: begin
                n_state = tsc_pkg::ST_RUN;
            end
        endcase

        // shrinking the history drops the oldest samples
        if (i_cfg.wr && (n_fill > new_lim)) begin
            n_fill = new_lim;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tsc_pkg::ST_RUN;
            r_wptr      <= '0;
            r_fill      <= '0;
            r_remain    <= '0;
            r_delay     <= '0;
            r_out_valid <= 1'b0;
            r_size      <= tsc_pkg::HIST_SIZE_RST;
        end else begin
            r_state     <= n_state;
            r_wptr      <= n_wptr;
            r_fill      <= n_fill;
            r_remain    <= n_remain;
            r_delay     <= n_delay;
            r_out_valid <= n_out_valid;
            if (i_cfg.wr) begin
                r_size <= i_cfg.size;
            end
        end
    end

    // dump pointers and result payload
    always_ff @(posedge i_clk) begin
        r_rptr   <= n_rptr;
        r_left   <= n_left;
        r_has    <= n_has;
        r_value  <= n_value;
        r_active <= n_active;
        r_last   <= n_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_has_value = r_has;
    assign o_value     = r_value;
    assign o_active    = r_active;
    assign o_last      = r_last;
    assign o_dumping   = (r_state == tsc_pkg::ST_DUMP);

endmodule

### rtl/triggered_sample_capture.sv
// Triggered capture with pre-trigger history: one result per request, but an arm request that
// starts a replay of m samples gives m results and none of its own. A result is registered at
// the edge that accepts its request beat; the first sample of a history replay is registered
// from the history read port once the result register can take it. One request per cycle
// while the result is not stalled; after the arm beat of a replay o_in_stall stays high until
// its last sample is loaded. Reset clears the write pointer, fill, count, delay and result
// valid, and sets hist_size to 32; history is not cleared and is only read inside the fill.
module triggered_sample_capture #(
    parameter int HISTORY_DEPTH = 32,
    parameter int SAMPLE_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_req_type,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_value,
    input  logic [15:0]                   i_trig_length,
    input  logic signed [15:0]            i_trig_offset,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_has_value,
    output logic signed [SAMPLE_BITS-1:0] o_value,
    output logic                          o_active,
    output logic                          o_last
);

    localparam int PW = $clog2(HISTORY_DEPTH);

    logic [5:0]              r_hist_size;
    tsc_pkg::t_cfg           cfg;
    logic                    dumping;
    logic                    mem_we;
    logic [PW-1:0]           mem_waddr;
    logic [SAMPLE_BITS-1:0]  mem_wdata;
    logic                    mem_re;
    logic [PW-1:0]           mem_raddr;
    logic [SAMPLE_BITS-1:0]  mem_rdata;

    // register write decode
    assign pready   = 1'b1;
    assign cfg.wr   = psel && penable && pwrite && pready
                      && (paddr[2] == tsc_pkg::REG_HIST_SIZE);
    assign cfg.size = pwdata[5:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_size <= tsc_pkg::HIST_SIZE_RST;
        end else if (cfg.wr) begin
            r_hist_size <= cfg.size;
        end
    end

    // register read
    assign prdata = (paddr[2] == tsc_pkg::REG_HIST_SIZE) ? {26'd0, r_hist_size} : 32'd0;

    tsc_ctrl #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_sample_value (i_sample_value),
        .i_trig_length  (i_trig_length),
        .i_trig_offset  (i_trig_offset),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_has_value    (o_has_value),
        .o_value        (o_value),
        .o_active       (o_active),
        .o_last         (o_last),
        .o_dumping      (dumping),
        .o_mem_we       (mem_we),
        .o_mem_waddr    (mem_waddr),
        .o_mem_wdata    (mem_wdata),
        .o_mem_re       (mem_re),
        .o_mem_raddr    (mem_raddr),
        .i_mem_rdata    (mem_rdata)
    );

    tsc_hist_mem #(
        .DEPTH (HISTORY_DEPTH),
        .WIDTH (SAMPLE_BITS)
    ) u_hist_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // replay holds off new requests
    a_dump_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dumping |-> o_in_stall)
        else $error("request accepted during history replay");

    // only replayed samples come as non-final beats
    a_nonlast_has_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> o_has_value)
        else $error("non-final beat without a sample");

    // an empty beat carries zero
    a_empty_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_has_value) |-> (o_value == '0))
        else $error("empty beat with nonzero value");

    // history is written only between replays
    a_no_write_in_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dumping |-> !mem_we)
        else $error("history written during replay");

endmodule
